// ----- hdl/bcs_pkg.sv -----
// Shared constants and types for the backtrack choice stack.
`default_nettype none

package bcs_pkg;

	localparam int unsigned CHOICE_W        = 8;
	localparam int unsigned ACTION_W        = 3;
	localparam int unsigned STACK_DEPTH_DEF = 256;

	localparam logic [CHOICE_W-1:0] MAX_CHOICE_RST = 8'd6;
	localparam logic [CHOICE_W-1:0] MIN_CHOICE     = 8'd5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND      = 3'd0,
		ACT_REWIND      = 3'd1,
		ACT_STEP        = 3'd2,
		ACT_READ_HIST   = 3'd3,
		ACT_QUERY       = 3'd4,
		ACT_NEXT_BRANCH = 3'd5,
		ACT_NEXT_TREE   = 3'd6,
		ACT_ROLLBACK    = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		MODE_FROM_MIN  = 2'd0,
		MODE_SPECIFIED = 2'd1,
		MODE_RUNNING   = 2'd2
	} mode_t;

endpackage

`default_nettype wire

// ----- hdl/bcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bcs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                                        clk,
	input  wire logic                                        wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                            wr_data,
	input  wire logic                                        rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/backtrack_choice_stack_unit.sv -----
// Top level of the backtrack choice stack: sequencer, state registers and result register.
//
//   channel   direction  handshake            word contents
//   --------  ---------  -------------------  -----------------------------------------
//   in        sink       in_valid / in_ready  action, choice_in
//   out       source     out_valid/out_ready  choice_out, entry_present, answer, error
//   cfg       sink       cfg_wr_en            cfg_wr_data -> max_choice
//
// Sequence: an action is accepted with its memory read issued, then executed using the read
// data, writing the RAM for append, next branch and the walk. Next tree and rollback take
// one execute step per entry visited by the odometer walk (popped entries plus the one that
// stays), one RAM read/write per cycle via the single incrementer/comparator unless stalled.
// Reset: clears cursor, length and mode, then a clearing pass zeroes the choice RAM, one
// entry per cycle through all STACK_DEPTH entries; in_ready stays low meanwhile.
// Stalls: execution waits while the result register still holds an untaken word.
`default_nettype none

module backtrack_choice_stack_unit
	import bcs_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_wr_en,
	input  wire logic [CHOICE_W-1:0] cfg_wr_data,
	// input words
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [CHOICE_W-1:0] choice_in,
	// result words
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [CHOICE_W-1:0] choice_out,
	output logic                     entry_present,
	output logic                     answer,
	output logic                     error
);

	localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	// cursor and length may reach STACK_DEPTH itself
	localparam int unsigned PTR_W  = $clog2(STACK_DEPTH + 1);
	localparam logic [PTR_W-1:0]  DEPTH_P = PTR_W'(STACK_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(STACK_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	action_t             act_q;
	logic [CHOICE_W-1:0] cin_q;
	logic [PTR_W-1:0]    cursor_q;
	logic [PTR_W-1:0]    len_q;
	mode_t               mode_q;
	logic [CHOICE_W-1:0] max_choice_q;

	logic                out_valid_q;
	logic [CHOICE_W-1:0] cout_q;
	logic                present_q;
	logic                answer_q;
	logic                err_q;

	// RAM port signals
	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [CHOICE_W-1:0] ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [CHOICE_W-1:0] ram_rd_data;

	// shared datapath
	logic                in_acc;
	logic                slot_free;
	logic                res_load;
	logic                cur_ok;
	logic [PTR_W:0]      cur_p1;
	logic [PTR_W-1:0]    len_m1;
	logic [PTR_W-1:0]    len_m2;
	logic [CHOICE_W-1:0] rd_inc;
	logic                inc_ok;
	logic                roll_in;

	// execute-cycle results
	logic                done;
	logic [PTR_W-1:0]    cursor_d;
	logic [PTR_W-1:0]    len_d;
	mode_t               mode_d;
	logic [CHOICE_W-1:0] r_cout;
	logic                r_present;
	logic                r_answer;
	logic                r_err;

	assign in_ready      = (state_q == ST_IDLE);
	assign in_acc        = in_valid & in_ready;
	assign slot_free     = !out_valid_q || out_ready;
	// result word loaded on the last execute cycle of an item
	assign res_load      = (state_q == ST_EXEC) && slot_free && done;

	assign out_valid     = out_valid_q;
	assign choice_out    = cout_q;
	assign entry_present = present_q;
	assign answer        = answer_q;
	assign error         = err_q;

	assign cur_ok  = (cursor_q < DEPTH_P);
	assign cur_p1  = {1'b0, cursor_q} + (PTR_W + 1)'(1);
	assign len_m1  = len_q - PTR_W'(1);
	assign len_m2  = len_q - PTR_W'(2);
	// the one incrementer and compare shared by next branch and the odometer walk
	assign rd_inc  = ram_rd_data + CHOICE_W'(1);
	assign inc_ok  = (rd_inc <= max_choice_q);
	assign roll_in = (action == ACT_NEXT_TREE) || (action == ACT_ROLLBACK);

	// Choice store
	bcs_ram #(
		.WIDTH (CHOICE_W),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// RAM control. The read for an item is issued in the accept cycle: the walk
	// actions start at the top entry, everything else reads at the cursor.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = cursor_q[ADDR_W-1:0];
		ram_wr_data = cin_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = cursor_q[ADDR_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
				ram_wr_data = '0;
			end
			ST_IDLE: begin
				ram_rd_en = in_acc;
				if (roll_in) begin
					ram_rd_addr = len_m1[ADDR_W-1:0];
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					unique case (act_q)
						ACT_APPEND: begin
							// cursor == length == depth also fails cur_ok
							ram_wr_en = cur_ok;
						end
						ACT_NEXT_BRANCH: begin
							ram_wr_en   = cur_ok && (mode_q != MODE_SPECIFIED);
							ram_wr_data = (mode_q == MODE_FROM_MIN) ? MIN_CHOICE : rd_inc;
						end
						ACT_NEXT_TREE, ACT_ROLLBACK: begin
							if (len_q != '0) begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = len_m1[ADDR_W-1:0];
								ram_wr_data = rd_inc;
								// entry overflowed and more remain: fetch the one below
								ram_rd_en   = !inc_ok && (len_q != PTR_W'(1));
								ram_rd_addr = len_m2[ADDR_W-1:0];
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Execute step: next state of the stack registers and the result word.
	always_comb begin
		done      = 1'b1;
		cursor_d  = cursor_q;
		len_d     = len_q;
		mode_d    = mode_q;
		r_cout    = '0;
		r_present = 1'b0;
		r_answer  = 1'b0;
		r_err     = 1'b0;
		unique case (act_q)
			ACT_APPEND: begin
				if (!cur_ok || ((cursor_q == len_q) && (len_q == DEPTH_P))) begin
					r_err = 1'b1;
				end else begin
					if (cursor_q == len_q) begin
						len_d = len_q + PTR_W'(1);
					end
					cursor_d = cursor_q + PTR_W'(1);
				end
			end
			ACT_REWIND: begin
				cursor_d = '0;
				mode_d   = (len_q != '0) ? MODE_SPECIFIED : MODE_FROM_MIN;
			end
			ACT_STEP: begin
				if (!cur_ok) begin
					r_err = 1'b1;
				end else begin
					// may read a stale entry beyond the length
					mode_d   = (cur_p1 >= {1'b0, len_q}) ? MODE_FROM_MIN : MODE_SPECIFIED;
					r_cout   = ram_rd_data;
					cursor_d = cursor_q + PTR_W'(1);
				end
			end
			ACT_READ_HIST: begin
				if ((cursor_q < len_q) && cur_ok) begin
					r_cout    = ram_rd_data;
					r_present = 1'b1;
					cursor_d  = cursor_q + PTR_W'(1);
				end
			end
			ACT_QUERY: begin
				if (mode_q != MODE_RUNNING) begin
					r_answer = 1'b1;
				end else if (cur_ok && (ram_rd_data < max_choice_q)) begin
					r_answer = 1'b1;
				end
			end
			ACT_NEXT_BRANCH: begin
				if (!cur_ok) begin
					r_err = 1'b1;
				end else begin
					if (mode_q != MODE_SPECIFIED) begin
						len_d = cursor_q + PTR_W'(1);
					end
					mode_d = MODE_RUNNING;
				end
			end
			ACT_NEXT_TREE, ACT_ROLLBACK: begin
				if (len_q == '0) begin
					r_err = 1'b1;
				end else if (inc_ok) begin
					// top entry stays in range: success
					r_answer = 1'b1;
					mode_d   = MODE_SPECIFIED;
					cursor_d = (act_q == ACT_NEXT_TREE) ? '0 : len_m1;
				end else if (len_q == PTR_W'(1)) begin
					// exhausted: last entry kept with its wrapped/overflowed value
					cursor_d = '0;
				end else begin
					// pop and keep walking
					done  = 1'b0;
					len_d = len_m1;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, stack registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			act_q       <= ACT_APPEND;
			cin_q       <= '0;
			cursor_q    <= '0;
			len_q       <= '0;
			mode_q      <= MODE_FROM_MIN;
			out_valid_q <= 1'b0;
			cout_q      <= '0;
			present_q   <= 1'b0;
			answer_q    <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						act_q   <= action_t'(action);
						cin_q   <= choice_in;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (slot_free) begin
						cursor_q <= cursor_d;
						len_q    <= len_d;
						mode_q   <= mode_d;
						if (done) begin
							cout_q    <= r_cout;
							present_q <= r_present;
							answer_q  <= r_answer;
							err_q     <= r_err;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// max_choice register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_choice_q <= MAX_CHOICE_RST;
		end else if (cfg_wr_en) begin
			max_choice_q <= cfg_wr_data;
		end
	end

endmodule

`default_nettype wire
